/* src/hts_pkg.sv */
// Shared constants and types of the HTML tokenizer stream block.
package hts_pkg;

  // Tokenizer modes
  localparam logic [4:0] M_DATA         = 5'd0;
  localparam logic [4:0] M_TAG_OPEN     = 5'd1;
  localparam logic [4:0] M_END_TAG_OPEN = 5'd2;
  localparam logic [4:0] M_TAG_NAME     = 5'd3;
  localparam logic [4:0] M_BEFORE_ANAME = 5'd4;
  localparam logic [4:0] M_ANAME        = 5'd5;
  localparam logic [4:0] M_AFTER_ANAME  = 5'd6;
  localparam logic [4:0] M_BEFORE_AVAL  = 5'd7;
  localparam logic [4:0] M_AVAL_DQ      = 5'd8;
  localparam logic [4:0] M_AVAL_SQ      = 5'd9;
  localparam logic [4:0] M_AVAL_UQ      = 5'd10;
  localparam logic [4:0] M_AFTER_AVAL   = 5'd11;
  localparam logic [4:0] M_SELF_CLOSE   = 5'd12;
  localparam logic [4:0] M_MARKUP       = 5'd13;
  localparam logic [4:0] M_MARKUP_DASH  = 5'd14;
  localparam logic [4:0] M_KEYWORD      = 5'd15;
  localparam logic [4:0] M_DOCTYPE      = 5'd16;
  localparam logic [4:0] M_COMMENT      = 5'd17;
  localparam logic [4:0] M_COMMENT_DASH = 5'd18;
  localparam logic [4:0] M_COMMENT_END  = 5'd19;
  localparam logic [4:0] M_BOGUS        = 5'd20;

  // Result kinds
  localparam logic [4:0] K_TEXT         = 5'd0;
  localparam logic [4:0] K_TAGNAME      = 5'd1;
  localparam logic [4:0] K_ANAME        = 5'd2;
  localparam logic [4:0] K_AVAL         = 5'd3;
  localparam logic [4:0] K_COMMENT      = 5'd4;
  localparam logic [4:0] K_DOCTYPE      = 5'd5;
  localparam logic [4:0] K_START_OPEN   = 5'd6;
  localparam logic [4:0] K_END_OPEN     = 5'd7;
  localparam logic [4:0] K_ATTR_DONE    = 5'd8;
  localparam logic [4:0] K_TAG_DONE     = 5'd9;
  localparam logic [4:0] K_SELF_DONE    = 5'd10;
  localparam logic [4:0] K_COMMENT_DONE = 5'd11;
  localparam logic [4:0] K_DOCTYPE_DONE = 5'd12;
  localparam logic [4:0] K_TEXT_END     = 5'd13;
  localparam logic [4:0] K_EOF          = 5'd14;
  localparam logic [4:0] K_ERROR        = 5'd16;

  // Parse error numbers
  localparam logic [7:0] E_TAG_OPEN     = 8'd0;
  localparam logic [7:0] E_END_TAG_OPEN = 8'd1;
  localparam logic [7:0] E_AFTER_AVAL   = 8'd2;
  localparam logic [7:0] E_SELF_CLOSE   = 8'd3;

  localparam int KEYWORD_LENGTH = 7;
  localparam int LA_DEPTH       = KEYWORD_LENGTH - 1;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic eof_ph;
    logic push;
    logic commit_byte;
    logic commit_eof;
    logic fin_move;
    logic [3:0] idx;
  } hts_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [3:0] total;
    logic can_push;
    logic again;
    logic byte_valid;
    logic end_of_input;
    logic hold_valid;
  } hts_sts_t;

  // Upper-case keyword letter at a given position
  function automatic logic [7:0] keyword_char(input logic [2:0] c);
    case (c)
      3'd0: keyword_char = 8'h44;
      3'd1: keyword_char = 8'h4F;
      3'd2: keyword_char = 8'h43;
      3'd3: keyword_char = 8'h54;
      3'd4: keyword_char = 8'h59;
      3'd5: keyword_char = 8'h50;
      3'd6: keyword_char = 8'h45;
      default: keyword_char = 8'h00;
    endcase
  endfunction

endpackage

/* src/hts_datapath.sv */
// Datapath: tokenizer state, lookahead, step decode, result hold and output registers.
module hts_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  hts_pkg::hts_cmd_t cmd,
  output hts_pkg::hts_sts_t sts,
  input  logic [7:0]        in_data_byte,
  input  logic              in_byte_valid,
  input  logic              in_end_of_input,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [4:0]        out_result_kind,
  output logic [7:0]        out_result_value,
  output logic              out_last_of_run
);

  logic [4:0] mode_r;
  logic       tp_r, an_r, ds_r;
  logic [2:0] cnt_r;
  logic [7:0] la_r [hts_pkg::LA_DEPTH];
  logic [7:0] byte_r;
  logic       bv_r, eoi_r;
  logic       hold_v_r;
  logic [4:0] hold_k_r;
  logic [7:0] hold_d_r;
  logic       out_v_r;
  logic [4:0] out_k_r;
  logic [7:0] out_d_r;
  logic       out_l_r;

  // Step decode results
  logic [4:0] lk [4];
  logic [7:0] lv [4];
  logic [1:0] nn;
  logic [4:0] mode_nxt;
  logic       tp_nxt, an_nxt, ds_nxt, again, flush, la_we;
  logic [2:0] cnt_nxt, la_wi;

  function automatic logic is_sp(input logic [7:0] b);
    is_sp = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
            (b == 8'h0C) || (b == 8'h0D);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] b);
    lower = ((b >= 8'h41) && (b <= 8'h5A)) ? b + 8'd32 : b;
  endfunction

  function automatic logic [7:0] upper(input logic [7:0] b);
    upper = ((b >= 8'h61) && (b <= 8'h7A)) ? b - 8'd32 : b;
  endfunction

  // One pass of the tokenizer over the held byte, or the end-of-input run
  always_comb begin
    logic [7:0] b;
    b = byte_r;
    for (int i = 0; i < 4; i++) begin
      lk[i] = hts_pkg::K_COMMENT;
      lv[i] = 8'd0;
    end
    nn = 2'd0;
    mode_nxt = mode_r;
    tp_nxt = tp_r;
    an_nxt = an_r;
    ds_nxt = ds_r;
    cnt_nxt = cnt_r;
    again = 1'b0;
    flush = 1'b0;
    la_we = 1'b0;
    la_wi = 3'd0;
    if (cmd.eof_ph) begin
      if (mode_r == hts_pkg::M_KEYWORD) begin
        flush = 1'b1;
      end else if (mode_r == hts_pkg::M_MARKUP_DASH) begin
        lk[nn] = hts_pkg::K_COMMENT; lv[nn] = 8'h2D; nn = nn + 2'd1;
      end else if (mode_r == hts_pkg::M_DATA && tp_r) begin
        lk[nn] = hts_pkg::K_TEXT_END; nn = nn + 2'd1;
      end else if (mode_r == hts_pkg::M_DOCTYPE) begin
        lk[nn] = hts_pkg::K_DOCTYPE_DONE; nn = nn + 2'd1;
      end
      lk[nn] = hts_pkg::K_EOF; nn = nn + 2'd1;
    end else begin
      case (mode_r)
        hts_pkg::M_DATA: begin
          if (b == 8'h3C) begin
            if (tp_r) begin
              lk[nn] = hts_pkg::K_TEXT_END; nn = nn + 2'd1;
            end
            tp_nxt = 1'b0;
            mode_nxt = hts_pkg::M_TAG_OPEN;
          end else begin
            lk[nn] = hts_pkg::K_TEXT; lv[nn] = b; nn = nn + 2'd1;
            tp_nxt = 1'b1;
          end
        end
        hts_pkg::M_TAG_OPEN: begin
          if (b == 8'h2F) mode_nxt = hts_pkg::M_END_TAG_OPEN;
          else if (b == 8'h21) mode_nxt = hts_pkg::M_MARKUP;
          else if (is_alpha(b)) begin
            lk[0] = hts_pkg::K_START_OPEN;
            lk[1] = hts_pkg::K_TAGNAME; lv[1] = lower(b); nn = 2'd2;
            mode_nxt = hts_pkg::M_TAG_NAME;
          end else begin
            lk[0] = hts_pkg::K_ERROR; lv[0] = hts_pkg::E_TAG_OPEN;
            lk[1] = hts_pkg::K_TEXT; lv[1] = 8'h3C;
            lk[2] = hts_pkg::K_TEXT; lv[2] = b; nn = 2'd3;
            tp_nxt = 1'b1;
            mode_nxt = hts_pkg::M_DATA;
          end
        end
        hts_pkg::M_END_TAG_OPEN: begin
          if (is_alpha(b)) begin
            lk[0] = hts_pkg::K_END_OPEN;
            lk[1] = hts_pkg::K_TAGNAME; lv[1] = lower(b); nn = 2'd2;
            mode_nxt = hts_pkg::M_TAG_NAME;
          end else begin
            lk[0] = hts_pkg::K_ERROR; lv[0] = hts_pkg::E_END_TAG_OPEN;
            lk[1] = hts_pkg::K_COMMENT; lv[1] = b; nn = 2'd2;
            mode_nxt = hts_pkg::M_BOGUS;
          end
        end
        hts_pkg::M_TAG_NAME: begin
          if (is_sp(b)) mode_nxt = hts_pkg::M_BEFORE_ANAME;
          else if (b == 8'h2F) mode_nxt = hts_pkg::M_SELF_CLOSE;
          else if (b == 8'h3E) begin
            lk[0] = hts_pkg::K_TAG_DONE; nn = 2'd1;
            mode_nxt = hts_pkg::M_DATA;
          end else begin
            lk[0] = hts_pkg::K_TAGNAME; lv[0] = lower(b); nn = 2'd1;
          end
        end
        hts_pkg::M_BEFORE_ANAME: begin
          if (is_sp(b)) begin
          end else if (b == 8'h2F) mode_nxt = hts_pkg::M_SELF_CLOSE;
          else if (b == 8'h3E) begin
            lk[0] = hts_pkg::K_TAG_DONE; nn = 2'd1;
            mode_nxt = hts_pkg::M_DATA;
          end else begin
            an_nxt = 1'b1;
            lk[0] = hts_pkg::K_ANAME; lv[0] = lower(b); nn = 2'd1;
            mode_nxt = hts_pkg::M_ANAME;
          end
        end
        hts_pkg::M_ANAME, hts_pkg::M_AFTER_ANAME: begin
          if (is_sp(b)) mode_nxt = hts_pkg::M_AFTER_ANAME;
          else if (b == 8'h3D) mode_nxt = hts_pkg::M_BEFORE_AVAL;
          else if (mode_r == hts_pkg::M_ANAME && b != 8'h2F && b != 8'h3E) begin
            lk[0] = hts_pkg::K_ANAME; lv[0] = lower(b); nn = 2'd1;
          end else begin
            if (an_r) begin
              lk[nn] = hts_pkg::K_ATTR_DONE; nn = nn + 2'd1;
            end
            an_nxt = 1'b0;
            if (b == 8'h2F) mode_nxt = hts_pkg::M_SELF_CLOSE;
            else if (b == 8'h3E) begin
              lk[nn] = hts_pkg::K_TAG_DONE; nn = nn + 2'd1;
              mode_nxt = hts_pkg::M_DATA;
            end else begin
              an_nxt = 1'b1;
              lk[nn] = hts_pkg::K_ANAME; lv[nn] = lower(b); nn = nn + 2'd1;
              mode_nxt = hts_pkg::M_ANAME;
            end
          end
        end
        hts_pkg::M_BEFORE_AVAL: begin
          if (is_sp(b)) begin
          end else if (b == 8'h22) mode_nxt = hts_pkg::M_AVAL_DQ;
          else if (b == 8'h27) mode_nxt = hts_pkg::M_AVAL_SQ;
          else if (b == 8'h3E) begin
            if (an_r) begin
              lk[nn] = hts_pkg::K_ATTR_DONE; nn = nn + 2'd1;
            end
            an_nxt = 1'b0;
            lk[nn] = hts_pkg::K_TAG_DONE; nn = nn + 2'd1;
            mode_nxt = hts_pkg::M_DATA;
          end else begin
            lk[0] = hts_pkg::K_AVAL; lv[0] = b; nn = 2'd1;
            mode_nxt = hts_pkg::M_AVAL_UQ;
          end
        end
        hts_pkg::M_AVAL_DQ, hts_pkg::M_AVAL_SQ: begin
          if (b == ((mode_r == hts_pkg::M_AVAL_DQ) ? 8'h22 : 8'h27)) begin
            if (an_r) begin
              lk[nn] = hts_pkg::K_ATTR_DONE; nn = nn + 2'd1;
            end
            an_nxt = 1'b0;
            mode_nxt = hts_pkg::M_AFTER_AVAL;
          end else begin
            lk[0] = hts_pkg::K_AVAL; lv[0] = b; nn = 2'd1;
          end
        end
        hts_pkg::M_AVAL_UQ: begin
          if (is_sp(b) || b == 8'h3E) begin
            if (an_r) begin
              lk[nn] = hts_pkg::K_ATTR_DONE; nn = nn + 2'd1;
            end
            an_nxt = 1'b0;
            if (b == 8'h3E) begin
              lk[nn] = hts_pkg::K_TAG_DONE; nn = nn + 2'd1;
              mode_nxt = hts_pkg::M_DATA;
            end else begin
              mode_nxt = hts_pkg::M_BEFORE_ANAME;
            end
          end else begin
            lk[0] = hts_pkg::K_AVAL; lv[0] = b; nn = 2'd1;
          end
        end
        hts_pkg::M_AFTER_AVAL: begin
          if (is_sp(b)) mode_nxt = hts_pkg::M_BEFORE_ANAME;
          else if (b == 8'h2F) mode_nxt = hts_pkg::M_SELF_CLOSE;
          else if (b == 8'h3E) begin
            lk[0] = hts_pkg::K_TAG_DONE; nn = 2'd1;
            mode_nxt = hts_pkg::M_DATA;
          end else begin
            lk[0] = hts_pkg::K_ERROR; lv[0] = hts_pkg::E_AFTER_AVAL;
            lk[1] = hts_pkg::K_ANAME; lv[1] = lower(b); nn = 2'd2;
            an_nxt = 1'b1;
            mode_nxt = hts_pkg::M_ANAME;
          end
        end
        hts_pkg::M_SELF_CLOSE: begin
          if (b == 8'h3E) begin
            lk[0] = hts_pkg::K_SELF_DONE; nn = 2'd1;
            mode_nxt = hts_pkg::M_DATA;
          end else begin
            lk[0] = hts_pkg::K_ERROR; lv[0] = hts_pkg::E_SELF_CLOSE; nn = 2'd1;
            mode_nxt = hts_pkg::M_BEFORE_ANAME;
          end
        end
        hts_pkg::M_MARKUP: begin
          if (b == 8'h2D) mode_nxt = hts_pkg::M_MARKUP_DASH;
          else if (upper(b) == hts_pkg::keyword_char(3'd0)) begin
            la_we = 1'b1; la_wi = 3'd0; cnt_nxt = 3'd1;
            mode_nxt = hts_pkg::M_KEYWORD;
          end else begin
            lk[0] = hts_pkg::K_COMMENT; lv[0] = b; nn = 2'd1;
            mode_nxt = hts_pkg::M_BOGUS;
          end
        end
        hts_pkg::M_MARKUP_DASH: begin
          if (b == 8'h2D) mode_nxt = hts_pkg::M_COMMENT;
          else begin
            lk[0] = hts_pkg::K_COMMENT; lv[0] = 8'h2D; nn = 2'd1;
            mode_nxt = hts_pkg::M_BOGUS;
            again = 1'b1;
          end
        end
        hts_pkg::M_KEYWORD: begin
          if (cnt_r != 3'd0 && upper(b) == hts_pkg::keyword_char(cnt_r)) begin
            if (cnt_r == 3'(hts_pkg::KEYWORD_LENGTH - 1)) begin
              cnt_nxt = 3'd0;
              ds_nxt = 1'b1;
              mode_nxt = hts_pkg::M_DOCTYPE;
            end else begin
              la_we = 1'b1; la_wi = cnt_r; cnt_nxt = cnt_r + 3'd1;
            end
          end else begin
            flush = 1'b1;
            cnt_nxt = 3'd0;
            mode_nxt = hts_pkg::M_BOGUS;
            again = 1'b1;
          end
        end
        hts_pkg::M_DOCTYPE: begin
          if (b == 8'h3E) begin
            lk[0] = hts_pkg::K_DOCTYPE_DONE; nn = 2'd1;
            mode_nxt = hts_pkg::M_DATA;
          end else if (ds_r && (b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D)) begin
          end else begin
            ds_nxt = 1'b0;
            lk[0] = hts_pkg::K_DOCTYPE; lv[0] = b; nn = 2'd1;
          end
        end
        hts_pkg::M_COMMENT: begin
          if (b == 8'h2D) mode_nxt = hts_pkg::M_COMMENT_DASH;
          else begin
            lk[0] = hts_pkg::K_COMMENT; lv[0] = b; nn = 2'd1;
          end
        end
        hts_pkg::M_COMMENT_DASH: begin
          if (b == 8'h2D) mode_nxt = hts_pkg::M_COMMENT_END;
          else begin
            lv[0] = 8'h2D; lv[1] = b; nn = 2'd2;
            mode_nxt = hts_pkg::M_COMMENT;
          end
        end
        hts_pkg::M_COMMENT_END: begin
          if (b == 8'h3E) begin
            lk[0] = hts_pkg::K_COMMENT_DONE; nn = 2'd1;
            mode_nxt = hts_pkg::M_DATA;
          end else begin
            lv[0] = 8'h2D; lv[1] = 8'h2D; lv[2] = b; nn = 2'd3;
            mode_nxt = hts_pkg::M_COMMENT;
          end
        end
        hts_pkg::M_BOGUS: begin
          if (b == 8'h3E) begin
            lk[0] = hts_pkg::K_COMMENT_DONE; nn = 2'd1;
            mode_nxt = hts_pkg::M_DATA;
          end else begin
            lk[0] = hts_pkg::K_COMMENT; lv[0] = b; nn = 2'd1;
          end
        end
        default: mode_nxt = hts_pkg::M_DATA;
      endcase
    end
  end

  // Run length and the entry at the controller's index
  logic [3:0] fl;
  logic [3:0] rel;
  logic [4:0] ent_k;
  logic [7:0] ent_d;
  assign fl = flush ? {1'b0, cnt_r} : 4'd0;
  assign rel = cmd.idx - fl;
  always_comb begin
    if (cmd.idx < fl) begin
      ent_k = hts_pkg::K_COMMENT;
      ent_d = (cmd.idx[2:0] < 3'(hts_pkg::LA_DEPTH)) ? la_r[cmd.idx[2:0]] : 8'd0;
    end else begin
      ent_k = lk[rel[1:0]];
      ent_d = lv[rel[1:0]];
    end
  end

  assign sts.total        = fl + {2'b00, nn};
  assign sts.can_push     = !hold_v_r || !out_v_r || !out_stall;
  assign sts.again        = again;
  assign sts.byte_valid   = bv_r;
  assign sts.end_of_input = eoi_r;
  assign sts.hold_valid   = hold_v_r;

  // Tokenizer state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.commit_eof) begin
      mode_r <= hts_pkg::M_DATA;
      tp_r   <= 1'b0;
      an_r   <= 1'b0;
      ds_r   <= 1'b1;
      cnt_r  <= 3'd0;
    end else if (cmd.commit_byte) begin
      mode_r <= mode_nxt;
      tp_r   <= tp_nxt;
      an_r   <= an_nxt;
      ds_r   <= ds_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Lookahead bytes, no reset
  always_ff @(posedge clk) begin
    if (cmd.commit_byte && la_we && la_wi < 3'(hts_pkg::LA_DEPTH)) begin
      la_r[la_wi] <= byte_r;
    end
  end

  // Held input item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      byte_r <= in_data_byte;
      bv_r   <= in_byte_valid;
      eoi_r  <= in_end_of_input;
    end
  end

  // One-deep hold: the newest result waits until its last flag is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (cmd.push) begin
      hold_v_r <= 1'b1;
    end else if (cmd.fin_move) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      hold_k_r <= ent_k;
      hold_d_r <= ent_d;
    end
  end

  // Output register
  logic out_load;
  assign out_load = (cmd.push && hold_v_r) || cmd.fin_move;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_k_r <= hold_k_r;
      out_d_r <= hold_d_r;
      out_l_r <= cmd.fin_move;
    end
  end

  assign out_valid        = out_v_r;
  assign out_result_kind  = out_k_r;
  assign out_result_value = out_d_r;
  assign out_last_of_run  = out_l_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(hts_pkg::LA_DEPTH)) else $error("lookahead count out of range");
  a_cnt_mode: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 3'd0 |-> mode_r == hts_pkg::M_KEYWORD)
    else $error("lookahead held outside keyword match");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!hold_v_r || !out_v_r || !out_stall))
    else $error("result pushed with no room");
  a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_move |=> !hold_v_r) else $error("hold not drained at end of run");
`endif

endmodule

/* src/hts_ctrl.sv */
// Controller: sequences one input item through its results.
module hts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_valid,
  input  logic              out_stall,
  input  hts_pkg::hts_sts_t sts,
  output hts_pkg::hts_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       eof_r, eof_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    eof_nxt         = eof_r;
    cmd.latch       = 1'b0;
    cmd.push        = 1'b0;
    cmd.commit_byte = 1'b0;
    cmd.commit_eof  = 1'b0;
    cmd.fin_move    = 1'b0;
    cmd.idx         = idx_r;
    cmd.eof_ph      = eof_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          idx_nxt = 4'd0;
          state_nxt = S_EMIT;
          eof_nxt = 1'b0;
        end
      end
      S_EMIT: begin
        if (!eof_r && !sts.byte_valid) begin
          // No byte in this item: skip the tokenizer pass
          if (sts.end_of_input) eof_nxt = 1'b1;
          else state_nxt = S_FIN;
        end else if (idx_r < sts.total) begin
          if (sts.can_push) begin
            cmd.push = 1'b1;
            idx_nxt = idx_r + 4'd1;
          end
        end else if (eof_r) begin
          cmd.commit_eof = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.commit_byte = 1'b1;
          idx_nxt = 4'd0;
          if (!sts.again) begin
            if (sts.end_of_input) eof_nxt = 1'b1;
            else state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!sts.hold_valid) begin
          state_nxt = S_IDLE;
        end else if (!out_valid || !out_stall) begin
          cmd.fin_move = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 4'd0;
      eof_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      eof_r   <= eof_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> state_r != S_IDLE) else $error("item accepted but not taken up");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push, cmd.commit_byte, cmd.commit_eof, cmd.fin_move}))
    else $error("conflicting datapath commands");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> idx_r <= sts.total) else $error("result index past run");
`endif

endmodule

/* src/html_tokenizer_stream.sv */
// Top level of the streaming HTML tokenizer.
// An item is accepted, then each tokenizer pass pushes its results one by one and
// commits (a replay adds a second pass, end of input one more), then the run is
// closed; results pass through one output slot, and output stalls hold the item.
// Synchronous active-low reset returns the tokenizer to the data state.
module html_tokenizer_stream (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_valid,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_result_kind,
  output logic [7:0] out_result_value,
  output logic       out_last_of_run
);

  hts_pkg::hts_cmd_t cmd;
  hts_pkg::hts_sts_t sts;

  hts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hts_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_data_byte     (in_data_byte),
    .in_byte_valid    (in_byte_valid),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_value (out_result_value),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
